// ----- rtl/counting_semaphore_table_core_defines.svh -----
`ifndef COUNTING_SEMAPHORE_TABLE_CORE_DEFINES_SVH
`define COUNTING_SEMAPHORE_TABLE_CORE_DEFINES_SVH
// assertion helpers for the semaphore table core
`ifndef SYNTHESIS
`define CST_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CST_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CST_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/cst_pkg.sv -----
package cst_pkg;
  localparam int MaxSemaphores = 16;
  localparam int QueueDepth    = 8;

  localparam logic [2:0] ACT_OPEN   = 3'd0;
  localparam logic [2:0] ACT_CLOSE  = 3'd1;
  localparam logic [2:0] ACT_WAIT   = 3'd2;
  localparam logic [2:0] ACT_POST   = 3'd3;
  localparam logic [2:0] ACT_REMOVE = 3'd4;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BLOCKED     = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND   = 3'd2;
  localparam logic [2:0] ST_TABLE_FULL  = 3'd3;
  localparam logic [2:0] ST_QUEUE_FULL  = 3'd4;
  localparam logic [2:0] ST_HAS_WAITERS = 3'd5;
  localparam logic [2:0] ST_BAD_VALUE   = 3'd6;

  localparam logic [14:0] COUNT_MAX = 15'h7fff;

  typedef struct packed {
    logic [2:0]  status;
    logic        woken_valid;
    logic [7:0]  woken_pid;
    logic [14:0] count_now;
  } result_t;
endpackage

// ----- rtl/counting_semaphore_table_core.sv -----
// channel | dir | tdata fields (low bit up)                         | tuser
// in_     | in  | action[2:0] sem_id[34:3] init_value[50:35] proc_id[58:51] | -
// out_    | out | status[2:0] woken_valid[3] woken_pid[11:4] count_now[26:12] | -
// A lookup reads the entries in order, with a read state and a compare state for each;
// the result then passes through the execute state, any queue or table moves, and the done state.
// A post that wakes a waiter reads the queue head and shifts the rest up one slot; a close
// without waiters moves each later entry and its queue up one place; remove scans every
// waiter slot of each entry until the proc_id is found. Both memories have registered reads.
// Synchronous active-low reset clears the sequencer, the entry count and the output valid flag only.
// in_tready is high while idle and either no result is held or the held one is being taken.
`include "counting_semaphore_table_core_defines.svh"
module counting_semaphore_table_core import cst_pkg::*; #(
  parameter int MAX_SEMAPHORES = MaxSemaphores,
  parameter int QUEUE_DEPTH    = QueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // action, sem_id, init_value, proc_id
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // status, woken_valid, woken_pid, count_now
);
  localparam int EW = (MAX_SEMAPHORES > 1) ? $clog2(MAX_SEMAPHORES) : 1;
  localparam int NW = $clog2(MAX_SEMAPHORES + 1);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int PD = MAX_SEMAPHORES * QUEUE_DEPTH;
  localparam int PW = (PD > 1) ? $clog2(PD) : 1;
  localparam int RW = 32 + 15 + CW;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_FRD     = 5'd1;
  localparam logic [4:0] S_FCHK    = 5'd2;
  localparam logic [4:0] S_EXEC    = 5'd3;
  localparam logic [4:0] S_QRD     = 5'd4;
  localparam logic [4:0] S_QCHK    = 5'd5;
  localparam logic [4:0] S_SHRD    = 5'd6;
  localparam logic [4:0] S_SHWR    = 5'd7;
  localparam logic [4:0] S_CLRD    = 5'd8;
  localparam logic [4:0] S_CLWR    = 5'd9;
  localparam logic [4:0] S_CQRD    = 5'd10;
  localparam logic [4:0] S_CQWR    = 5'd11;
  localparam logic [4:0] S_DONE    = 5'd12;
  localparam logic [4:0] S_RERD    = 5'd13;
  localparam logic [4:0] S_RECHK   = 5'd14;
  localparam logic [4:0] S_FINW    = 5'd15;

  logic [4:0]  state_r, state_nxt;
  logic [NW-1:0] used_r, used_nxt;
  logic [2:0]  act_r, act_nxt;
  logic [31:0] id_r, id_nxt;
  logic [14:0] init_r, init_nxt;
  logic [7:0]  pid_r, pid_nxt;
  logic [NW-1:0] e_r, e_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [RW-1:0] ent_r, ent_nxt;
  logic        ovalid_r, ovalid_nxt;
  result_t     res_r, res_nxt;

  logic          e_we;
  logic [EW-1:0] e_wa, e_ra;
  logic [RW-1:0] e_wd, e_rd;
  logic          q_we;
  logic [PW-1:0] q_wa, q_ra;
  logic [7:0]    q_wd, q_rd;

  cst_ram #(.Width(RW), .Depth(MAX_SEMAPHORES)) u_ent (
    .clk(clk), .we(e_we), .waddr(e_wa), .wdata(e_wd), .raddr(e_ra), .rdata(e_rd));
  cst_ram #(.Width(8), .Depth(PD)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_wa), .wdata(q_wd), .raddr(q_ra), .rdata(q_rd));

  logic [31:0]   rd_id;
  logic [14:0]   rd_cnt;
  logic [CW-1:0] rd_wc;
  assign rd_id  = e_rd[RW-1 -: 32];
  assign rd_cnt = e_rd[CW +: 15];
  assign rd_wc  = e_rd[CW-1:0];

  logic [31:0]   en_id;
  logic [14:0]   en_cnt;
  logic [CW-1:0] en_wc;
  assign en_id  = ent_r[RW-1 -: 32];
  assign en_cnt = ent_r[CW +: 15];
  assign en_wc  = ent_r[CW-1:0];

  function automatic logic [PW-1:0] qaddr(input logic [NW-1:0] e, input logic [CW-1:0] k);
    logic [PW+NW+CW-1:0] a;
    a = PW'(0) + (PW+NW+CW)'(e) * (PW+NW+CW)'(QUEUE_DEPTH) + (PW+NW+CW)'(k);
    return a[PW-1:0];
  endfunction

  assign in_tready  = (state_r == S_IDLE) && !(ovalid_r && !out_tready);
  assign out_tvalid = ovalid_r;
  assign out_tdata  = {5'd0, res_r.count_now, res_r.woken_pid, res_r.woken_valid,
                       res_r.status};

  always_comb begin
    state_nxt = state_r; used_nxt = used_r; act_nxt = act_r; id_nxt = id_r;
    init_nxt = init_r; pid_nxt = pid_r; e_nxt = e_r; k_nxt = k_r;
    ent_nxt = ent_r; res_nxt = res_r;
    ovalid_nxt = ovalid_r && !out_tready;
    e_we = 1'b0; e_wa = e_r[EW-1:0]; e_wd = ent_r; e_ra = e_r[EW-1:0];
    q_we = 1'b0; q_wa = qaddr(e_r, k_r); q_wd = pid_r; q_ra = qaddr(e_r, k_r);
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          act_nxt = in_tdata[2:0]; id_nxt = in_tdata[34:3];
          init_nxt = in_tdata[49:35]; pid_nxt = in_tdata[58:51];
          e_nxt = '0; k_nxt = '0;
          res_nxt = '{status: ST_OK, woken_valid: 1'b0, woken_pid: 8'd0, count_now: 15'd0};
          if (in_tdata[2:0] == ACT_OPEN && used_r >= NW'(MAX_SEMAPHORES)) begin
            res_nxt.status = ST_TABLE_FULL; state_nxt = S_DONE;
          end else if (in_tdata[2:0] == ACT_OPEN && in_tdata[50]) begin
            res_nxt.status = ST_BAD_VALUE; state_nxt = S_DONE;
          end else if (in_tdata[2:0] > ACT_REMOVE) begin
            res_nxt.status = ST_BAD_VALUE; state_nxt = S_DONE;
          end else begin
            state_nxt = S_FRD;
          end
        end
      end
      S_FRD: begin
        if (e_r == used_r) begin
          state_nxt = S_EXEC;
        end else begin
          state_nxt = S_FCHK;
        end
      end
      S_FCHK: begin
        ent_nxt = e_rd;
        if (act_r == ACT_REMOVE) begin
          k_nxt = '0; state_nxt = S_RERD;
        end else if (rd_id == id_r) begin
          state_nxt = S_EXEC;
        end else begin
          e_nxt = e_r + 1'b1; state_nxt = S_FRD;
        end
      end
      S_RERD: begin
        if (k_r == en_wc) begin
          e_nxt = e_r + 1'b1; state_nxt = S_FRD;
        end else begin
          state_nxt = S_RECHK;
        end
      end
      S_RECHK: begin
        if (q_rd == pid_r) begin
          res_nxt.count_now = en_cnt; state_nxt = S_SHRD;
          k_nxt = k_r + 1'b1;
        end else begin
          k_nxt = k_r + 1'b1; state_nxt = S_RERD;
        end
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        if (e_r == used_r) begin
          if (act_r == ACT_OPEN) begin
            e_we = 1'b1;
            e_wd = {id_r, init_r, CW'(0)};
            used_nxt = used_r + 1'b1;
            res_nxt.count_now = init_r;
          end else if (act_r == ACT_REMOVE) begin
            res_nxt.status = ST_NOT_FOUND;
          end else begin
            res_nxt.status = ST_NOT_FOUND;
          end
        end else begin
          case (act_r)
            ACT_OPEN: res_nxt.count_now = en_cnt;
            ACT_CLOSE: begin
              if (en_wc != '0) begin
                res_nxt.status = ST_HAS_WAITERS; res_nxt.count_now = en_cnt;
              end else begin
                state_nxt = S_CLRD;
              end
            end
            ACT_WAIT: begin
              if (en_cnt != '0) begin
                e_we = 1'b1; e_wd = {en_id, en_cnt - 1'b1, en_wc};
                res_nxt.count_now = en_cnt - 1'b1;
              end else if (en_wc >= CW'(QUEUE_DEPTH)) begin
                res_nxt.status = ST_QUEUE_FULL;
              end else begin
                q_we = 1'b1; q_wa = qaddr(e_r, en_wc); q_wd = pid_r;
                e_we = 1'b1; e_wd = {en_id, en_cnt, en_wc + 1'b1};
                res_nxt.status = ST_BLOCKED;
              end
            end
            ACT_POST: begin
              res_nxt.count_now = en_cnt;
              if (en_wc != '0) begin
                res_nxt.woken_valid = 1'b1; k_nxt = CW'(1); state_nxt = S_QRD;
              end else if (en_cnt < COUNT_MAX) begin
                e_we = 1'b1; e_wd = {en_id, en_cnt + 1'b1, en_wc};
                res_nxt.count_now = en_cnt + 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_QRD: begin
        q_ra = qaddr(e_r, '0); state_nxt = S_QCHK;
      end
      S_QCHK: begin
        res_nxt.woken_pid = q_rd; state_nxt = S_SHRD;
      end
      S_SHRD: begin
        if (k_r >= en_wc) begin
          state_nxt = S_FINW;
        end else begin
          state_nxt = S_SHWR;
        end
      end
      S_SHWR: begin
        q_we = 1'b1; q_wa = qaddr(e_r, k_r - 1'b1); q_wd = q_rd;
        k_nxt = k_r + 1'b1; state_nxt = S_SHRD;
      end
      S_FINW: begin
        e_we = 1'b1; e_wd = {en_id, en_cnt, en_wc - 1'b1}; state_nxt = S_DONE;
      end
      S_CLRD: begin
        if (e_r + 1'b1 >= used_r) begin
          used_nxt = used_r - 1'b1; state_nxt = S_DONE;
        end else begin
          e_ra = EW'(e_r + 1'b1); state_nxt = S_CLWR;
        end
      end
      S_CLWR: begin
        e_we = 1'b1; e_wd = e_rd; ent_nxt = e_rd; k_nxt = '0; state_nxt = S_CQRD;
      end
      S_CQRD: begin
        if (k_r >= en_wc) begin
          e_nxt = e_r + 1'b1; state_nxt = S_CLRD;
        end else begin
          q_ra = qaddr(e_r + 1'b1, k_r); state_nxt = S_CQWR;
        end
      end
      S_CQWR: begin
        q_we = 1'b1; q_wa = qaddr(e_r, k_r); q_wd = q_rd;
        k_nxt = k_r + 1'b1; state_nxt = S_CQRD;
      end
      S_DONE: begin
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; used_r <= '0; ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt; used_r <= used_nxt; ovalid_r <= ovalid_nxt;
    end
    act_r <= act_nxt; id_r <= id_nxt; init_r <= init_nxt; pid_r <= pid_nxt;
    e_r <= e_nxt; k_r <= k_nxt; ent_r <= ent_nxt; res_r <= res_nxt;
  end

  `CST_ASSERT_IMPL(a_used_bound, clk, rst_n, 1'b1, used_r <= NW'(MAX_SEMAPHORES))
  `CST_ASSERT_IMPL(a_woken_post, clk, rst_n, out_tvalid && out_tdata[3],
    out_tdata[2:0] == ST_OK)
  `CST_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata))
endmodule

// ----- rtl/cst_ram.sv -----
module cst_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr,
  input  logic [Width-1:0]                        wdata,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr,
  output logic [Width-1:0]                        rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- tb/counting_semaphore_table_core_tb.sv -----
module counting_semaphore_table_core_tb;
  import cst_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 50000;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] sem_id;
    logic [15:0] init_value;
    logic [7:0]  proc_id;
  } request_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;

  counting_semaphore_table_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  logic [31:0] sem_ids  [MaxSemaphores];
  logic [14:0] sem_cnts [MaxSemaphores];
  int          queue_len[MaxSemaphores];
  logic [7:0]  queue_pid[MaxSemaphores][QueueDepth];
  int          sems_open;

  result_t     pending_results[$];
  int          mismatches;
  int          idle_cycles;
  bit          sender_steady;
  bit          receiver_steady;
  bit          hold_off;

  logic [31:0] id_pool[8];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int find_sem(logic [31:0] id);
    for (int i = 0; i < sems_open; i++) begin
      if (sem_ids[i] == id) return i;
    end
    return sems_open;
  endfunction

  function automatic void drop_waiter(int e, int pos);
    for (int k = pos; k + 1 < queue_len[e]; k++) queue_pid[e][k] = queue_pid[e][k+1];
    queue_len[e]--;
  endfunction

  function automatic result_t semaphore_outcome(request_t r);
    result_t res;
    int e;
    bit done;
    res = '0;
    res.status = ST_OK;
    case (r.action)
      ACT_OPEN: begin
        if (sems_open >= MaxSemaphores) res.status = ST_TABLE_FULL;
        else if (r.init_value[15]) res.status = ST_BAD_VALUE;
        else begin
          e = find_sem(r.sem_id);
          if (e == sems_open) begin
            sem_ids[e] = r.sem_id;
            sem_cnts[e] = r.init_value[14:0];
            queue_len[e] = 0;
            sems_open++;
          end
          res.count_now = sem_cnts[e];
        end
      end
      ACT_CLOSE: begin
        e = find_sem(r.sem_id);
        if (e == sems_open) res.status = ST_NOT_FOUND;
        else if (queue_len[e] != 0) begin
          res.status = ST_HAS_WAITERS;
          res.count_now = sem_cnts[e];
        end else begin
          for (int i = e; i + 1 < sems_open; i++) begin
            sem_ids[i] = sem_ids[i+1];
            sem_cnts[i] = sem_cnts[i+1];
            queue_len[i] = queue_len[i+1];
            queue_pid[i] = queue_pid[i+1];
          end
          sems_open--;
        end
      end
      ACT_WAIT: begin
        e = find_sem(r.sem_id);
        if (e == sems_open) res.status = ST_NOT_FOUND;
        else if (sem_cnts[e] != 0) begin
          sem_cnts[e]--;
          res.count_now = sem_cnts[e];
        end else if (queue_len[e] >= QueueDepth) res.status = ST_QUEUE_FULL;
        else begin
          queue_pid[e][queue_len[e]] = r.proc_id;
          queue_len[e]++;
          res.status = ST_BLOCKED;
        end
      end
      ACT_POST: begin
        e = find_sem(r.sem_id);
        if (e == sems_open) res.status = ST_NOT_FOUND;
        else begin
          if (queue_len[e] != 0) begin
            res.woken_valid = 1'b1;
            res.woken_pid = queue_pid[e][0];
            drop_waiter(e, 0);
          end else if (sem_cnts[e] < COUNT_MAX) sem_cnts[e]++;
          res.count_now = sem_cnts[e];
        end
      end
      ACT_REMOVE: begin
        res.status = ST_NOT_FOUND;
        done = 1'b0;
        for (int i = 0; i < sems_open && !done; i++) begin
          for (int j = 0; j < queue_len[i] && !done; j++) begin
            if (queue_pid[i][j] == r.proc_id) begin
              drop_waiter(i, j);
              res.status = ST_OK;
              res.count_now = sem_cnts[i];
              done = 1'b1;
            end
          end
        end
      end
      default: res.status = ST_BAD_VALUE;
    endcase
    return res;
  endfunction

  task automatic send_request(logic [2:0] act, logic [31:0] id, logic [15:0] val,
                              logic [7:0] pid);
    request_t r;
    r.action = act;
    r.sem_id = id;
    r.init_value = val;
    r.proc_id = pid;
    while (!sender_steady && $urandom_range(99) < 9) @(posedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {5'b0, r.proc_id, r.init_value, r.sem_id, r.action};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(semaphore_outcome(r));
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (!hold_off && (receiver_steady || $urandom_range(99) >= 9)) out_tready <= 1'b1;
      else out_tready <= 1'b0;
    end
  end

  always @(posedge clk) begin
    result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = out_tdata[2:0];
      got.woken_valid = out_tdata[3];
      got.woken_pid = out_tdata[11:4];
      got.count_now = out_tdata[26:12];
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.woken_valid !== want.woken_valid ||
            got.woken_pid !== want.woken_pid || got.count_now !== want.count_now) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected st=%0d wv=%0d pid=%0d cnt=%0d",
                      " got st=%0d wv=%0d pid=%0d cnt=%0d"},
                     want.status, want.woken_valid, want.woken_pid, want.count_now,
                     got.status, got.woken_valid, got.woken_pid, got.count_now);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_request(ACT_OPEN, 32'h0, 16'h8000, 8'h00);
    send_request(ACT_OPEN, 32'hffffffff, 16'h7fff, 8'hff);
    send_request(ACT_POST, 32'hffffffff, 16'h0, 8'h0);
    send_request(ACT_OPEN, 32'hffffffff, 16'h0005, 8'h0);
    send_request(ACT_OPEN, 32'h0, 16'h0, 8'h0);
    send_request(ACT_WAIT, 32'h0, 16'hffff, 8'hff);
    send_request(ACT_WAIT, 32'h0, 16'h0, 8'h01);
    send_request(ACT_CLOSE, 32'h0, 16'h0, 8'h0);
    send_request(ACT_POST, 32'h0, 16'h0, 8'h0);
    send_request(ACT_REMOVE, 32'h0, 16'h0, 8'h01);
    send_request(ACT_REMOVE, 32'h0, 16'h0, 8'h77);
    send_request(ACT_CLOSE, 32'h1234, 16'h0, 8'h0);
    send_request(ACT_WAIT, 32'h1234, 16'h0, 8'h0);
    send_request(ACT_POST, 32'h1234, 16'h0, 8'h0);
    send_request(3'd5, 32'h0, 16'h0, 8'h0);
    send_request(3'd7, 32'hffffffff, 16'hffff, 8'hff);
    for (int i = 0; i < 9; i++) send_request(ACT_WAIT, 32'h0, 16'h0, 8'(i + 8'h10));
    send_request(ACT_CLOSE, 32'hffffffff, 16'h0, 8'h0);
  endtask

  task automatic test_table_full();
    for (int i = 0; i < 17; i++) send_request(ACT_OPEN, 32'h100 + i, 16'h0003, 8'h0);
    send_request(ACT_OPEN, 32'h100, 16'h0, 8'h0);
    send_request(ACT_OPEN, 32'h200, 16'h8000, 8'h0);
    send_request(ACT_CLOSE, 32'h105, 16'h0, 8'h0);
    for (int i = 0; i < 16; i++) send_request(ACT_CLOSE, 32'h100 + i, 16'h0, 8'h0);
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 12; i++) send_request(ACT_OPEN, id_pool[i % 8], 16'h2, 8'h0);
    join
    drain_results();
  endtask

  task automatic test_random(int n);
    logic [2:0] act;
    logic [31:0] id;
    logic [15:0] val;
    logic [7:0] pid;
    for (int i = 0; i < n; i++) begin
      if (i == n / 3) begin
        sender_steady = 1'b1;
        receiver_steady = 1'b1;
      end
      if (i == n / 2) begin
        sender_steady = 1'b0;
        receiver_steady = 1'b0;
        drain_results();
      end
      case ($urandom_range(99)) inside
        [0:14]:  act = ACT_OPEN;
        [15:24]: act = ACT_CLOSE;
        [25:54]: act = ACT_WAIT;
        [55:79]: act = ACT_POST;
        [80:94]: act = ACT_REMOVE;
        default: act = 3'($urandom_range(7));
      endcase
      id = ($urandom_range(19) == 0) ? $urandom : id_pool[$urandom_range(7)];
      case ($urandom_range(9))
        0: val = 16'($urandom);
        1: val = 16'h7fff;
        2: val = 16'h7ffe;
        default: val = 16'($urandom_range(3));
      endcase
      pid = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(15));
      send_request(act, id, val, pid);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    mismatches = 0;
    idle_cycles = 0;
    sender_steady = 1'b0;
    receiver_steady = 1'b0;
    hold_off = 1'b0;
    sems_open = 0;
    for (int i = 0; i < 8; i++) id_pool[i] = (i < 2) ? {32{i[0]}} : $urandom;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_table_full();
    test_backpressure();
    test_random(1350);
    drain_results();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
